### hdl/scr_pkg.sv
// Shared types and constants for the second-chance page replacer.
// Used by scr_page_ram and second_chance_page_replacer; no dependencies.
package scr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int FAULT_W   = 16;
  localparam int EVICT_W   = 16;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_reference;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted_valid;
    logic [EVICT_W-1:0] evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_PLACE  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

### hdl/scr_page_ram.sv
// Page store: one page number per frame, one write and one registered read port.
// Depends on scr_pkg.
module scr_page_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [scr_pkg::IDX_W-1:0]      wr_addr,
  input  logic [scr_pkg::PAGE_BITS-1:0]  wr_data,
  input  logic [scr_pkg::IDX_W-1:0]      rd_addr,
  output logic [scr_pkg::PAGE_BITS-1:0]  rd_data
);

  logic [scr_pkg::PAGE_BITS-1:0] mem [scr_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/second_chance_page_replacer.sv
// Top level: clock (second-chance) page replacer with a one-frame-per-cycle scan unit.
// Depends on scr_pkg and scr_page_ram.
//
//   channel  | direction | handshake                 | payload
//   in_      | input     | in_valid / in_stall       | scr_pkg::in_t
//   out_     | output    | out_valid / out_stall     | scr_pkg::out_t
//   cfg_     | input     | cfg_wr_en (no wait)       | frames_in_use, 5 bits
//
// One beat at a time. A hit ends the lookup at the matching frame; a miss compares
// all n frames in use, then the hand clears each set reference bit it passes until
// it finds a clear one (n = frames in use). The page store has a single read port,
// shared by the lookup and the hand. in_stall is high while a beat is in work.
// rst_n is synchronous; it empties all frames and sets frames_in_use to 16.
// A result waiting under out_stall holds the block in its final step.
module second_chance_page_replacer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  scr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output scr_pkg::out_t                   out_data,
  input  logic                            cfg_wr_en,
  input  logic [scr_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int IW = scr_pkg::IDX_W;
  localparam int CW = scr_pkg::CNT_W;
  localparam int NF = scr_pkg::FRAMES;

  scr_pkg::state_t                state_r, state_nxt;
  logic [scr_pkg::CFG_W-1:0]      cfg_frames_r;
  logic [scr_pkg::PAGE_BITS-1:0]  page_r, page_nxt;
  logic                           last_r, last_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [IW-1:0]                  pend_idx_r, pend_idx_nxt;
  logic [NF-1:0]                  valid_r, valid_nxt;
  logic [NF-1:0]                  ref_r, ref_nxt;
  logic [IW-1:0]                  hand_r, hand_nxt;
  logic [scr_pkg::FAULT_W-1:0]    fault_r, fault_nxt;
  scr_pkg::out_t                  res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  scr_pkg::out_t                  out_data_r, out_data_nxt;

  logic [CW-1:0]                  active_n;
  logic [IW-1:0]                  hand_inc;
  logic [scr_pkg::FAULT_W-1:0]    fault_inc;
  logic                           match;
  logic                           ram_wr_en;
  logic [IW-1:0]                  ram_rd_addr;
  logic [scr_pkg::PAGE_BITS-1:0]  ram_rd_data;

  scr_page_ram u_page_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (hand_r),
    .wr_data (page_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    if (cfg_frames_r == '0) begin
      active_n = CW'(1);
    end else if (32'(cfg_frames_r) > NF) begin
      active_n = CW'(NF);
    end else begin
      active_n = CW'(cfg_frames_r);
    end
  end

  assign hand_inc  = ((CW'(hand_r) + CW'(1)) == active_n) ? '0 : hand_r + IW'(1);
  assign fault_inc = (fault_r == '1) ? fault_r : fault_r + scr_pkg::FAULT_W'(1);
  assign match     = pend_r && valid_r[pend_idx_r] && (ram_rd_data == page_r);
  assign ram_rd_addr = (state_r == scr_pkg::ST_LOOKUP) ? idx_r[IW-1:0] : hand_r;
  assign ram_wr_en   = (state_r == scr_pkg::ST_PLACE);

  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    valid_nxt     = valid_r;
    ref_nxt       = ref_r;
    hand_nxt      = hand_r;
    fault_nxt     = fault_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      scr_pkg::ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_data.page_number;
          last_nxt  = in_data.last_reference;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = scr_pkg::ST_LOOKUP;
        end
      end
      scr_pkg::ST_LOOKUP: begin
        if (idx_r < active_n) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IW-1:0];
          idx_nxt      = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (match) begin
          ref_nxt[pend_idx_r]   = 1'b1;
          res_nxt.hit           = 1'b1;
          res_nxt.frame_slot    = scr_pkg::SLOT_W'(pend_idx_r);
          res_nxt.evicted_valid = 1'b0;
          res_nxt.evicted_page  = '0;
          res_nxt.fault_count   = fault_r;
          state_nxt             = scr_pkg::ST_DONE;
        end else if (!pend_r && (idx_r >= active_n)) begin
          hand_nxt  = (CW'(hand_r) >= active_n) ? '0 : hand_r;
          state_nxt = scr_pkg::ST_SWEEP;
        end
      end
      scr_pkg::ST_SWEEP: begin
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_inc;
        end else begin
          state_nxt = scr_pkg::ST_PLACE;
        end
      end
      scr_pkg::ST_PLACE: begin
        valid_nxt[hand_r]     = 1'b1;
        ref_nxt[hand_r]       = 1'b0;
        hand_nxt              = hand_inc;
        fault_nxt             = fault_inc;
        res_nxt.hit           = 1'b0;
        res_nxt.frame_slot    = scr_pkg::SLOT_W'(hand_r);
        res_nxt.evicted_valid = valid_r[hand_r];
        res_nxt.evicted_page  = valid_r[hand_r]
                                ? scr_pkg::EVICT_W'(ram_rd_data) : '0;
        res_nxt.fault_count   = fault_inc;
        state_nxt             = scr_pkg::ST_DONE;
      end
      scr_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          if (last_r) begin
            valid_nxt = '0;
            ref_nxt   = '0;
            hand_nxt  = '0;
            fault_nxt = '0;
          end
          state_nxt = scr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scr_pkg::ST_IDLE;
      cfg_frames_r <= scr_pkg::CFG_W'(16);
      idx_r        <= '0;
      pend_r       <= 1'b0;
      valid_r      <= '0;
      ref_r        <= '0;
      hand_r       <= '0;
      fault_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        cfg_frames_r <= cfg_wr_data;
      end
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      valid_r      <= valid_nxt;
      ref_r        <= ref_nxt;
      hand_r       <= hand_nxt;
      fault_r      <= fault_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != scr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb_second_chance_page_replacer.sv
// Testbench for second_chance_page_replacer: directed table, then random reference
// strings under several frame counts, checked beat by beat.
// Depends on scr_pkg and the RTL under hdl/.
module tb_second_chance_page_replacer;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_REFS    = 1950;

  typedef struct {
    bit             is_cfg;
    logic [4:0]     cfg_val;
    scr_pkg::in_t   beat;
    bit             typed;
    scr_pkg::out_t  want;
  } plan_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  scr_pkg::in_t              in_data;
  logic                      out_valid;
  logic                      out_stall;
  scr_pkg::out_t             out_data;
  logic                      cfg_wr_en;
  logic [scr_pkg::CFG_W-1:0] cfg_wr_data;

  logic [scr_pkg::PAGE_BITS-1:0] frame_pages [scr_pkg::FRAMES];
  bit                            frame_full  [scr_pkg::FRAMES];
  bit                            ref_bit     [scr_pkg::FRAMES];
  int                            hand_pos;
  logic [scr_pkg::FAULT_W-1:0]   faults;
  logic [scr_pkg::CFG_W-1:0]     frames_cfg;

  scr_pkg::out_t pending_results [$];
  plan_row_t     plan [$];
  int            mismatch_count;
  int            idle_cycles;
  bit            quiet;

  second_chance_page_replacer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int frames_active(logic [scr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > scr_pkg::FRAMES) return scr_pkg::FRAMES;
    return int'(v);
  endfunction

  function automatic void clear_string();
    for (int i = 0; i < scr_pkg::FRAMES; i++) begin
      frame_full[i] = 1'b0;
      ref_bit[i]    = 1'b0;
    end
    hand_pos = 0;
    faults   = '0;
  endfunction

  function automatic scr_pkg::out_t predict_page_ref(scr_pkg::in_t b);
    scr_pkg::out_t r;
    int   n;
    int   h;
    int   slot;
    bit   found;
    n     = frames_active(frames_cfg);
    r     = '0;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_full[i] && frame_pages[i] == b.page_number) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      ref_bit[slot] = 1'b1;
    end else begin
      h = (hand_pos >= n) ? 0 : hand_pos;
      for (int i = 0; i <= n; i++) begin
        if (!ref_bit[h]) break;
        ref_bit[h] = 1'b0;
        h = (h + 1) % n;
      end
      slot = h;
      if (frame_full[slot]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_pages[slot];
      end
      frame_pages[slot] = b.page_number;
      frame_full[slot]  = 1'b1;
      ref_bit[slot]     = 1'b0;
      hand_pos          = (h + 1) % n;
      if (faults != 16'hFFFF) faults = faults + 1'b1;
    end
    r.hit         = found;
    r.frame_slot  = slot[scr_pkg::SLOT_W-1:0];
    r.fault_count = faults;
    if (b.last_reference) clear_string();
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [4:0] v);
    plan_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic plan_row_t pg_row(logic [15:0] pg, logic lr);
    plan_row_t r;
    r                     = '{default: '0};
    r.beat.page_number    = pg;
    r.beat.last_reference = lr;
    return r;
  endfunction

  function automatic plan_row_t chk_row(logic [15:0] pg, logic lr, logic h, logic [3:0] s,
                                        logic ev, logic [15:0] ep, logic [15:0] fc);
    plan_row_t r;
    r                    = pg_row(pg, lr);
    r.typed              = 1'b1;
    r.want.hit           = h;
    r.want.frame_slot    = s;
    r.want.evicted_valid = ev;
    r.want.evicted_page  = ep;
    r.want.fault_count   = fc;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drop valid, wait for the block to drain, then write the frame count.
  task automatic set_frames(logic [scr_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || in_stall) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    frames_cfg = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic issue_ref(scr_pkg::in_t b, bit typed, scr_pkg::out_t want);
    scr_pkg::out_t pred;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_page_ref(b);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    scr_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", out_data.hit, want.hit));
        if (out_data.frame_slot !== want.frame_slot)
          report_mismatch($sformatf("frame_slot got %0d want %0d",
                                    out_data.frame_slot, want.frame_slot));
        if (out_data.evicted_valid !== want.evicted_valid)
          report_mismatch($sformatf("evicted_valid got %b want %b",
                                    out_data.evicted_valid, want.evicted_valid));
        if (out_data.evicted_page !== want.evicted_page)
          report_mismatch($sformatf("evicted_page got %h want %h",
                                    out_data.evicted_page, want.evicted_page));
        if (out_data.fault_count !== want.fault_count)
          report_mismatch($sformatf("fault_count got %0d want %0d",
                                    out_data.fault_count, want.fault_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    scr_pkg::in_t  b;
    scr_pkg::out_t none;
    int            sent;
    int            len;
    int            psz;
    logic [4:0]    fv;
    logic [15:0]   base;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    mismatch_count = 0;
    quiet          = 1'b0;
    none           = '0;
    frames_cfg     = 5'd16;
    for (int i = 0; i < scr_pkg::FRAMES; i++) frame_pages[i] = '0;
    clear_string();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    plan = '{
      chk_row(16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd1),
      chk_row(16'hFFFF, 1'b0, 1'b0, 4'd1, 1'b0, 16'h0000, 16'd2),
      chk_row(16'h0000, 1'b0, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd2),
      chk_row(16'hFFFF, 1'b1, 1'b1, 4'd1, 1'b0, 16'h0000, 16'd2),
      chk_row(16'h1234, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd1),
      cfg_row(5'd1),
      chk_row(16'h1234, 1'b0, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd1),
      pg_row(16'h5678, 1'b0),
      cfg_row(5'd0),
      pg_row(16'h5678, 1'b0),
      pg_row(16'hABCD, 1'b0),
      cfg_row(5'd31),
      pg_row(16'h0001, 1'b0),
      pg_row(16'h0002, 1'b0),
      pg_row(16'h0003, 1'b0),
      pg_row(16'h0004, 1'b0),
      pg_row(16'h0005, 1'b0),
      pg_row(16'h0002, 1'b0),
      cfg_row(5'd3),
      pg_row(16'h0005, 1'b0),
      cfg_row(5'd16),
      pg_row(16'h0005, 1'b0),
      pg_row(16'h8000, 1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_frames(plan[i].cfg_val);
      else issue_ref(plan[i].beat, plan[i].typed, plan[i].want);
    end

    sent = 0;
    while (sent < RANDOM_REFS) begin
      case ($urandom_range(0, 5))
        0:       fv = 5'd0;
        1:       fv = 5'd1;
        2:       fv = 5'd16;
        3:       fv = 5'd31;
        default: fv = 5'($urandom_range(0, 31));
      endcase
      set_frames(fv);
      len  = $urandom_range(4, 48);
      base = 16'($urandom);
      psz  = $urandom_range(1, 2 * frames_active(fv) + 2);
      for (int k = 0; k < len; k++) begin
        b.page_number = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : base ^ 16'($urandom_range(0, psz - 1));
        if (k == len - 1) b.last_reference = ($urandom_range(0, 3) != 0);
        else b.last_reference = ($urandom_range(0, 59) == 0);
        quiet = (sent >= 700 && sent < 1000);
        issue_ref(b, 1'b0, none);
        sent++;
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * scr_pkg::FRAMES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
